[rtl/rlp_pkg.sv]
// Shared types, constants and helper functions of the rectangle layout packer.
package rlp_pkg;

  localparam int DEF_MAX_PARTS = 64;
  localparam int DEF_DIM_BITS  = 16;
  localparam int CALC_W        = 34;
  localparam logic [15:0] MARGIN_RESET = 16'd160;
  localparam logic [23:0] SAT24 = 24'hFFFFFF;

  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_DOWN  = 2'd2;

  typedef struct packed {
    logic [15:0] part_width;
    logic [15:0] part_height;
    logic        final_part;
  } part_t;

  typedef struct packed {
    logic [5:0]  part_index;
    logic [23:0] offset_x;
    logic [23:0] offset_y;
    logic [23:0] layout_width;
    logic [23:0] layout_height;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic load;
    logic rd_k;
    logic key_latch;
    logic rd_j;
    logic cmp;
    logic rk_write;
    logic pl_ord;
    logic pl_dim;
    logic pl_calc;
    logic em_rd;
    logic em_out;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic k_last;
    logic i_last;
  } stat_t;

  function automatic logic [23:0] sat24(input logic [CALC_W-1:0] v);
    logic [23:0] r;
    if (v > CALC_W'(SAT24)) r = SAT24;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic [CALC_W-1:0] sub0(input logic [CALC_W-1:0] a,
                                             input logic [CALC_W-1:0] b);
    logic [CALC_W-1:0] r;
    if (a > b) r = a - b;
    else r = '0;
    return r;
  endfunction

endpackage

[rtl/rectangle_layout_packer.sv]
// Top level of the rectangle layout packer: controller plus datapath.
// Rectangles are taken one per cycle while busy is low (start high); an item
// arriving with the store full is dropped. An item with final_part set closes
// the set and the block raises busy: it ranks each stored rectangle by its
// larger side against every other, reading one stored size at a time through
// the single read port of the size store, places them in ranked order and
// then emits the results one by one, each held for exactly one cycle with
// result_valid high. The receiver cannot stall, so it must take every result
// as it appears. Busy falls on the cycle the last result is presented, and the
// next set can start loading at once.
module rectangle_layout_packer import rlp_pkg::*; #(
  parameter int MAX_PARTS = DEF_MAX_PARTS,
  parameter int DIM_BITS  = DEF_DIM_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  part_t       part,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output result_t     result,
  output logic        result_valid
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence loading, ranking, placement and emission
  rlp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .final_part (part.final_part),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Hold the sizes, order, offsets and running totals
  rlp_datapath #(
    .MAX_PARTS (MAX_PARTS),
    .DIM_BITS  (DIM_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .part         (part),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

[rtl/rlp_ctrl.sv]
// Sequencing state machine of the rectangle layout packer.
module rlp_ctrl import rlp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  final_part,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_RK_K  = 4'd1;
  localparam logic [3:0] S_RK_KL = 4'd2;
  localparam logic [3:0] S_RK_J  = 4'd3;
  localparam logic [3:0] S_RK_JC = 4'd4;
  localparam logic [3:0] S_RK_W  = 4'd5;
  localparam logic [3:0] S_P_ORD = 4'd6;
  localparam logic [3:0] S_P_DIM = 4'd7;
  localparam logic [3:0] S_P_CAL = 4'd8;
  localparam logic [3:0] S_E_RD  = 4'd9;
  localparam logic [3:0] S_E_OUT = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        cmd.load = start;
        if (start && final_part) state_next = S_RK_K;
      end
      S_RK_K: begin
        cmd.rd_k = 1'b1;
        state_next = S_RK_KL;
      end
      S_RK_KL: begin
        cmd.key_latch = 1'b1;
        state_next = S_RK_J;
      end
      S_RK_J: begin
        cmd.rd_j = 1'b1;
        state_next = S_RK_JC;
      end
      S_RK_JC: begin
        cmd.cmp = 1'b1;
        state_next = stat.j_last ? S_RK_W : S_RK_J;
      end
      S_RK_W: begin
        cmd.rk_write = 1'b1;
        state_next = stat.k_last ? S_P_ORD : S_RK_K;
      end
      S_P_ORD: begin
        cmd.pl_ord = 1'b1;
        state_next = S_P_DIM;
      end
      S_P_DIM: begin
        cmd.pl_dim = 1'b1;
        state_next = S_P_CAL;
      end
      S_P_CAL: begin
        cmd.pl_calc = 1'b1;
        state_next = stat.i_last ? S_E_RD : S_P_ORD;
      end
      S_E_RD: begin
        cmd.em_rd = 1'b1;
        state_next = S_E_OUT;
      end
      S_E_OUT: begin
        cmd.em_out = 1'b1;
        state_next = stat.i_last ? S_LOAD : S_E_RD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  assign busy = (state != S_LOAD);

endmodule

[rtl/rlp_datapath.sv]
// Stores, ranking counters and placement arithmetic of the rectangle layout packer.
module rlp_datapath import rlp_pkg::*; #(
  parameter int MAX_PARTS = DEF_MAX_PARTS,
  parameter int DIM_BITS  = DEF_DIM_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  part_t       part,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output stat_t       stat,
  output result_t     result,
  output logic        result_valid
);

  localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 1);

  logic [DIM_BITS-1:0] store_w [MAX_PARTS];
  logic [DIM_BITS-1:0] store_h [MAX_PARTS];
  logic [IW-1:0]       ord_mem [MAX_PARTS];
  logic [23:0]         offx_mem [MAX_PARTS];
  logic [23:0]         offy_mem [MAX_PARTS];

  logic [CW-1:0] count;
  logic [15:0]   margin;
  logic [IW-1:0] k, j, jd, i, rank, ordq;
  logic [DIM_BITS-1:0] rw, rh, keyk;
  logic [23:0] offxq, offyq, tw, th;
  logic [24:0] gx, gy;
  logic [1:0]  side;

  logic [DIM_BITS+15:0] ext_w, ext_h;
  logic [DIM_BITS-1:0]  in_w, in_h, key_rd;
  logic [IW-1:0]        rd_addr;
  logic [IW+5:0]        idx_ext;
  logic                 room;

  assign ext_w = {{DIM_BITS{1'b0}}, part.part_width};
  assign ext_h = {{DIM_BITS{1'b0}}, part.part_height};
  assign in_w  = ext_w[DIM_BITS-1:0];
  assign in_h  = ext_h[DIM_BITS-1:0];
  assign room  = (count < CW'(MAX_PARTS));
  assign key_rd = (rw > rh) ? rw : rh;
  assign idx_ext = {6'd0, ordq};

  assign stat.j_last = ((IW+1)'(j) + (IW+1)'(1)) == (IW+1)'(count);
  assign stat.k_last = ((IW+1)'(k) + (IW+1)'(1)) == (IW+1)'(count);
  assign stat.i_last = ((IW+1)'(i) + (IW+1)'(1)) == (IW+1)'(count);

  always_comb begin
    rd_addr = ordq;
    if (cmd.rd_k) rd_addr = k;
    else if (cmd.rd_j) rd_addr = j;
  end

  // Placement of the rectangle at rank i
  logic [CALC_W-1:0] cw, ch, cm, ctw, cth, cgx, cgy, px, py;
  logic [23:0] ntw, nth, npx, npy;
  logic [24:0] ngx, ngy;
  logic [1:0]  nside;

  always_comb begin
    cw  = CALC_W'(rw);
    ch  = CALC_W'(rh);
    cm  = CALC_W'(margin);
    ctw = CALC_W'(tw);
    cth = CALC_W'(th);
    cgx = CALC_W'(gx);
    cgy = CALC_W'(gy);
    px  = '0;
    py  = '0;
    ntw = tw;
    nth = th;
    ngx = gx;
    ngy = gy;
    nside = side;
    if (i == '0) begin
      ntw = sat24(cw);
      nth = sat24(ch);
      ngx = '0;
      ngy = '0;
      nside = SIDE_NONE;
    end else if (cgx > cw && cgy > ch) begin
      px = sub0(ctw, cgx);
      py = sub0(cth, cgy);
      if (side == SIDE_RIGHT) py = CALC_W'(sat24(py + cm));
      if (side == SIDE_DOWN)  px = CALC_W'(sat24(px + cm));
      if (cw > ch) ngy = 25'(sub0(cgy, ch + cm));
      else ngx = 25'(sub0(cgx, cw + cm));
    end else if (tw < th) begin
      px = CALC_W'(sat24(ctw + cm));
      ntw = sat24(ctw + cw + cm);
      ngy = 25'(sub0(cth, ch));
      ngx = 25'(sat24(cw));
      nside = SIDE_RIGHT;
    end else begin
      py = CALC_W'(sat24(cth + cm));
      nth = sat24(cth + ch + cm);
      ngx = 25'(sub0(ctw, cw));
      ngy = 25'(sat24(ch));
      nside = SIDE_DOWN;
    end
    npx = px[23:0];
    npy = py[23:0];
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      store_w[count[IW-1:0]] <= in_w;
      store_h[count[IW-1:0]] <= in_h;
    end
    if (cmd.rd_k || cmd.rd_j || cmd.pl_dim) begin
      rw <= store_w[rd_addr];
      rh <= store_h[rd_addr];
    end
    if (cmd.rk_write) ord_mem[rank] <= k;
    if (cmd.pl_ord || cmd.em_rd) ordq <= ord_mem[i];
    if (cmd.pl_calc) begin
      offx_mem[i] <= npx;
      offy_mem[i] <= npy;
    end
    if (cmd.em_rd) begin
      offxq <= offx_mem[i];
      offyq <= offy_mem[i];
    end
  end

  // Ranking: rank of k counts larger keys and equal keys that arrived earlier
  always_ff @(posedge clk) begin
    if (cmd.key_latch) keyk <= key_rd;
    if (cmd.rd_j) jd <= j;
    if (cmd.em_out) begin
      result.part_index    <= idx_ext[5:0];
      result.offset_x      <= offxq;
      result.offset_y      <= offyq;
      result.layout_width  <= tw;
      result.layout_height <= th;
      result.run_end       <= stat.i_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      margin <= MARGIN_RESET;
      k <= '0;
      j <= '0;
      i <= '0;
      rank <= '0;
      tw <= '0;
      th <= '0;
      gx <= '0;
      gy <= '0;
      side <= SIDE_NONE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.em_out;
      if (cfg_we) margin <= cfg_data;
      if (cmd.load) begin
        if (room) count <= count + CW'(1);
        k <= '0;
        i <= '0;
      end
      if (cmd.key_latch) begin
        j <= '0;
        rank <= '0;
      end
      if (cmd.cmp) begin
        if (key_rd > keyk || (key_rd == keyk && jd < k)) rank <= rank + IW'(1);
        j <= j + IW'(1);
      end
      if (cmd.rk_write) k <= k + IW'(1);
      if (cmd.pl_calc) begin
        tw <= ntw;
        th <= nth;
        gx <= ngx;
        gy <= ngy;
        side <= nside;
        i <= stat.i_last ? '0 : i + IW'(1);
      end
      if (cmd.em_out) begin
        i <= stat.i_last ? '0 : i + IW'(1);
        if (stat.i_last) count <= '0;
      end
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe held two cycles");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PARTS)) else $error("store count beyond capacity");
  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rk_write |-> ((IW+1)'(rank) < (IW+1)'(count))) else $error("rank outside set");

endmodule

[tb/sv/tb_top.sv]
// Testbench for the rectangle layout packer: random sets checked against a packing predictor.
`timescale 1ns / 1ps

module tb_top import rlp_pkg::*;;

  // Scoreboard: keep a copy of the loaded set, pack it on the final item and
  // hold the expected placements until the block emits them.
  class layout_scoreboard;
    logic [15:0] set_w[$];
    logic [15:0] set_h[$];
    logic [15:0] margin;
    result_t     placements_q[$];
    int          mismatches;
    int          failures;

    function new();
      margin = MARGIN_RESET;
      mismatches = 0;
      failures = 0;
    endfunction

    function longint unsigned clamp24(longint unsigned v);
      return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
    endfunction

    function longint unsigned floor_sub(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : 0;
    endfunction

    function longint unsigned long_side(int k);
      return (set_w[k] > set_h[k]) ? set_w[k] : set_h[k];
    endfunction

    function bit pending();
      return placements_q.size() != 0;
    endfunction

    // Place the set: stable sort by larger side, largest first, then fill gaps
    // or grow to the right or downward.
    function void pack_set();
      int order[$];
      int n, j, key;
      longint unsigned tw, th, gx, gy, px, py, w, h, m;
      logic [1:0] side;
      result_t r[$];
      result_t one;
      n = set_w.size();
      m = margin;
      for (int i = 0; i < n; i++) order = {order, i};
      for (int i = 1; i < n; i++) begin
        key = order[i];
        j = i;
        while (j > 0 && long_side(order[j-1]) < long_side(key)) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = key;
      end
      tw = clamp24(set_w[order[0]]);
      th = clamp24(set_h[order[0]]);
      gx = 0;
      gy = 0;
      side = SIDE_NONE;
      for (int i = 0; i < n; i++) begin
        w = set_w[order[i]];
        h = set_h[order[i]];
        px = 0;
        py = 0;
        if (i > 0) begin
          if (gx > w && gy > h) begin
            px = floor_sub(tw, gx);
            py = floor_sub(th, gy);
            if (side == SIDE_RIGHT) py = clamp24(py + m);
            if (side == SIDE_DOWN) px = clamp24(px + m);
            if (w > h) gy = floor_sub(gy, h + m);
            else gx = floor_sub(gx, w + m);
          end else if (tw < th) begin
            px = clamp24(tw + m);
            tw = clamp24(tw + w + m);
            gy = floor_sub(th, h);
            gx = clamp24(w);
            side = SIDE_RIGHT;
          end else begin
            py = clamp24(th + m);
            th = clamp24(th + h + m);
            gx = floor_sub(tw, w);
            gy = clamp24(h);
            side = SIDE_DOWN;
          end
        end
        one.part_index = order[i][5:0];
        one.offset_x = px[23:0];
        one.offset_y = py[23:0];
        one.run_end = (i == n - 1);
        r = {r, one};
      end
      foreach (r[i]) begin
        r[i].layout_width = tw[23:0];
        r[i].layout_height = th[23:0];
        placements_q = {placements_q, r[i]};
      end
      set_w.delete();
      set_h.delete();
    endfunction

    // Note an accepted item: store it unless the set is full, pack on the last.
    function void note_part(part_t p);
      if (set_w.size() < DEF_MAX_PARTS) begin
        set_w = {set_w, p.part_width};
        set_h = {set_h, p.part_height};
      end
      if (p.final_part && set_w.size() > 0) pack_set();
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (placements_q.size() == 0) begin
        failures++;
        if (mismatches < 10) $display("unexpected result %p", got);
        mismatches++;
        return;
      end
      exp = placements_q.pop_front();
      if (got.part_index !== exp.part_index || got.offset_x !== exp.offset_x ||
          got.offset_y !== exp.offset_y || got.layout_width !== exp.layout_width ||
          got.layout_height !== exp.layout_height || got.run_end !== exp.run_end) begin
        failures++;
        if (mismatches < 10) $display("mismatch: expected %p, got %p", exp, got);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  part_t       part;
  logic        cfg_we;
  logic [15:0] cfg_data;
  result_t     result;
  logic        result_valid;

  layout_scoreboard sb;
  int items_sent;
  bit no_gaps;

  rectangle_layout_packer u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .part(part),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result(result), .result_valid(result_valid)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take every strobed result at the edge that closes its cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  // Short gaps mostly, now and then a long one; none at all in burst sets.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (no_gaps || r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_part(input logic [15:0] w, input logic [15:0] h, input logic fin);
    int gap;
    part <= '{part_width: w, part_height: h, final_part: fin};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_part('{part_width: w, part_height: h, final_part: fin});
    items_sent++;
    gap = pick_gap();
    // Drop start after the last item so a stale item is never taken.
    if (fin || gap > 0) begin
      start <= 1'b0;
      repeat ((gap > 0) ? gap : 1) @(posedge clk);
    end
  endtask

  // Write the margin only with the block idle and nothing outstanding.
  task automatic set_margin(input logic [15:0] v);
    start <= 1'b0;
    while (sb.pending()) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    sb.margin = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_part(pick_dim(), pick_dim(), i == n - 1);
  endtask

  initial begin
    int n;
    sb = new();
    items_sent = 0;
    no_gaps = 0;
    rst = 1'b1;
    start = 1'b0;
    part = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single rectangle of zero size at the reset margin.
    send_part(16'd0, 16'd0, 1'b1);
    // Full-scale sides, with one side zero.
    send_part(16'hFFFF, 16'hFFFF, 1'b0);
    send_part(16'hFFFF, 16'd0, 1'b0);
    send_part(16'd0, 16'hFFFF, 1'b1);
    // No margin: small rectangles drop into the leftover gap.
    set_margin(16'd0);
    send_part(16'd100, 16'd100, 1'b0);
    send_part(16'd30, 16'd10, 1'b0);
    send_part(16'd10, 16'd30, 1'b0);
    send_part(16'd5, 16'd5, 1'b0);
    send_part(16'd1, 16'd1, 1'b1);
    // Ties on the larger side must keep arrival order.
    set_margin(16'hFFFF);
    send_part(16'd10, 16'd20, 1'b0);
    send_part(16'd20, 16'd10, 1'b0);
    send_part(16'd20, 16'd5, 1'b0);
    send_part(16'd5, 16'd20, 1'b1);
    set_margin(16'd2);
    send_part(16'd200, 16'd40, 1'b0);
    send_part(16'd40, 16'd200, 1'b0);
    send_part(16'd30, 16'd10, 1'b0);
    send_part(16'd8, 16'd8, 1'b0);
    send_part(16'd3, 16'd3, 1'b1);

    // Random sets, mostly small, margin changed between some of them.
    while (items_sent < 210) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_margin(16'd0);
          1: set_margin(16'hFFFF);
          2: set_margin(MARGIN_RESET);
          default: set_margin(16'($urandom_range(0, 65535)));
        endcase
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      n = $urandom_range(0, 9);
      if (n < 7) n = $urandom_range(1, 6);
      else if (n < 9) n = $urandom_range(7, 20);
      else n = $urandom_range(40, 64);
      send_random_set(n);
    end
    // Overfill the store: the extra items are dropped, packing still runs.
    no_gaps = 0;
    set_margin(16'($urandom_range(0, 300)));
    send_random_set(DEF_MAX_PARTS + 2);

    start <= 1'b0;
    while (sb.pending()) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.failures == 0 && !sb.pending()) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
